// File: src/sum_tree_weighted_sampler_core_defines.svh
// Assertion macros shared by the sum tree sampler RTL.
// Expects clk and rst in scope at the point of use.
`ifndef SUM_TREE_WEIGHTED_SAMPLER_CORE_DEFINES_SVH
`define SUM_TREE_WEIGHTED_SAMPLER_CORE_DEFINES_SVH

// same-cycle implication
`define STW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/stw_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and datapath operation codes for the sum tree sampler.
// No dependencies.
package stw_pkg;

  localparam int LEAVES_DEF        = 1024;
  localparam int WEIGHT_BITS_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 24;

  localparam int LEAF_PORT_W  = 10;
  localparam int DELTA_W      = 32;
  localparam int FRAC_PORT_W  = 24;
  localparam int TOTAL_PORT_W = 32;

  localparam int S_LEAF_LSB  = 0;
  localparam int S_DELTA_LSB = S_LEAF_LSB + LEAF_PORT_W;
  localparam int S_FRAC_LSB  = S_DELTA_LSB + DELTA_W;
  localparam int S_TDATA_W   = 72;
  localparam int S_TUSER_W   = 1;

  localparam int M_LEAF_LSB  = 0;
  localparam int M_TOTAL_LSB = M_LEAF_LSB + LEAF_PORT_W;
  localparam int M_TDATA_W   = 48;
  localparam int M_TUSER_W   = 2;

  typedef logic [2:0] op_t;

  localparam op_t OP_NONE   = 3'd0;
  localparam op_t OP_CLEAR  = 3'd1;
  localparam op_t OP_LOAD   = 3'd2;
  localparam op_t OP_UP     = 3'd3;
  localparam op_t OP_MUL    = 3'd4;
  localparam op_t OP_TOTAL  = 3'd5;
  localparam op_t OP_TGT    = 3'd6;
  localparam op_t OP_DESC   = 3'd7;

  typedef struct packed {
    op_t  op;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_update_ok;
    logic in_sample;
    logic at_root;
    logic rd_zero;
    logic next_leaf;
    logic clr_last;
  } stat_t;

endpackage

// File: src/stw_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the sum tree sampler: clear pass, update walk, sample descent.
// Depends on stw_pkg and the assertion macro header.
`include "sum_tree_weighted_sampler_core_defines.svh"
module stw_ctrl import stw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_UP    = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_TOTAL = 3'd4;
  localparam logic [2:0] S_TGT   = 3'd5;
  localparam logic [2:0] S_DESC  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.emit   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op = OP_LOAD;
          if (st.in_sample) state_next = S_ROOT;
          else if (st.in_update_ok) state_next = S_UP;
          else state_next = S_TOTAL;
        end
      end
      S_UP: begin
        cmd.op = OP_UP;
        if (st.at_root) state_next = S_DONE;
      end
      S_ROOT: begin
        cmd.op = OP_MUL;
        state_next = st.rd_zero ? S_DONE : S_TGT;
      end
      S_TOTAL: begin
        cmd.op = OP_TOTAL;
        state_next = S_DONE;
      end
      S_TGT: begin
        cmd.op = OP_TGT;
        state_next = S_DESC;
      end
      S_DESC: begin
        cmd.op = OP_DESC;
        if (st.next_leaf) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  `STW_ASSERT_NOW(a_clear_quiet, state == S_CLEAR, !m_tvalid && !s_tready, "transfer during clear")
  `STW_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state != S_IDLE && state != S_CLEAR, "accept did not start work")
  `STW_ASSERT_NEXT(a_result_loads, state == S_DONE && out_free, m_tvalid && state == S_IDLE, "result not presented")

endmodule

// File: src/stw_dp.sv
`timescale 1ns / 1ps
// Datapath for the sum tree sampler: node memory, saturating update, scaling
// multiply and descent compare. Depends on stw_pkg and the assertion macros.
`include "sum_tree_weighted_sampler_core_defines.svh"
module stw_dp import stw_pkg::*; #(
  parameter int LEAVES        = LEAVES_DEF,
  parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                st,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [M_TUSER_W-1:0] m_tuser
);

  localparam int LEVELS     = $clog2(LEAVES);
  localparam int NODE_W     = LEVELS + 1;
  localparam int NODES      = 2 * LEAVES - 1;
  localparam int FIRST_LEAF = LEAVES - 1;
  localparam int SUM_W      = ((WEIGHT_BITS > DELTA_W) ? WEIGHT_BITS : DELTA_W) + 2;
  localparam int CUM_W      = WEIGHT_BITS + $clog2(LEVELS) + 1;
  localparam int LO_W       = (WEIGHT_BITS + 1) / 2;
  localparam int HI_W       = WEIGHT_BITS - LO_W;
  localparam int PROD_W     = FRACTION_BITS + WEIGHT_BITS;
  localparam int FX_W       = (FRACTION_BITS > FRAC_PORT_W) ? FRACTION_BITS : FRAC_PORT_W;
  localparam logic [NODE_W-1:0] FIRST_LEAF_N = NODE_W'(FIRST_LEAF);
  localparam logic [NODE_W-1:0] LAST_NODE_N  = NODE_W'(NODES - 1);
  localparam logic [NODE_W-1:0] ONE_N        = NODE_W'(1);

  logic [WEIGHT_BITS-1:0] mem [NODES];
  logic [WEIGHT_BITS-1:0] rd;

  logic                      mode_r;
  logic [LEAF_PORT_W-1:0]    leaf_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic [FRACTION_BITS-1:0]  frac_r;
  logic [NODE_W-1:0]         cur;
  logic [CUM_W-1:0]          cumul;
  logic [WEIGHT_BITS-1:0]    target;
  logic [WEIGHT_BITS-1:0]    total;
  logic [FRACTION_BITS+HI_W-1:0] p_hi;
  logic [FRACTION_BITS+LO_W-1:0] p_lo;
  logic                      clip;
  logic                      empty;
  logic [NODE_W-1:0]         clr_cnt;

  logic [LEAF_PORT_W-1:0]  out_leaf;
  logic [TOTAL_PORT_W-1:0] out_total;
  logic                    out_empty;
  logic                    out_clip;

  logic                   in_mode;
  logic [LEAF_PORT_W-1:0] in_leaf;
  logic [DELTA_W-1:0]     in_delta;
  logic [FRAC_PORT_W-1:0] in_frac;
  logic [FX_W-1:0]        frac_wide;
  logic                   in_ok;
  logic [NODE_W-1:0]      leaf_node;
  logic [NODE_W-1:0]      parent;

  logic signed [SUM_W-1:0] upd_sum;
  logic [WEIGHT_BITS-1:0]  clamped;
  logic                    clamp_hit;

  logic [CUM_W-1:0]   left_sum;
  logic               go_left;
  logic [NODE_W-1:0]  child_l;
  logic [NODE_W-1:0]  next_node;
  logic               next_leaf;
  logic [PROD_W-1:0]  prod;

  logic                   we;
  logic [NODE_W-1:0]      wa;
  logic [WEIGHT_BITS-1:0] wd;
  logic [NODE_W-1:0]      ra;

  assign in_mode   = s_tuser[0];
  assign in_leaf   = s_tdata[S_LEAF_LSB +: LEAF_PORT_W];
  assign in_delta  = s_tdata[S_DELTA_LSB +: DELTA_W];
  assign in_frac   = s_tdata[S_FRAC_LSB +: FRAC_PORT_W];
  assign frac_wide = FX_W'(in_frac);
  assign in_ok     = !in_mode && (32'(in_leaf) < 32'(LEAVES));
  assign leaf_node = FIRST_LEAF_N + NODE_W'(in_leaf);
  assign parent    = NODE_W'((cur - ONE_N) >> 1);

  always_comb begin
    upd_sum   = $signed(SUM_W'(rd)) + SUM_W'(delta_r);
    clamped   = upd_sum[WEIGHT_BITS-1:0];
    clamp_hit = 1'b0;
    if (upd_sum[SUM_W-1]) begin
      clamped   = '0;
      clamp_hit = 1'b1;
    end else if (|upd_sum[SUM_W-2:WEIGHT_BITS]) begin
      clamped   = '1;
      clamp_hit = 1'b1;
    end
  end

  assign left_sum  = cumul + CUM_W'(rd);
  assign go_left   = CUM_W'(target) <= left_sum;
  assign child_l   = NODE_W'({cur, 1'b1});
  assign next_node = go_left ? child_l : child_l + ONE_N;
  assign next_leaf = next_node >= FIRST_LEAF_N;
  assign prod      = (PROD_W'(p_hi) << LO_W) + PROD_W'(p_lo);

  always_comb begin
    we = 1'b0;
    wa = cur;
    wd = clamped;
    ra = '0;
    unique case (cmd.op)
      OP_CLEAR: begin
        we = 1'b1;
        wa = clr_cnt;
        wd = '0;
      end
      OP_LOAD:  ra = in_ok ? leaf_node : '0;
      OP_UP: begin
        we = 1'b1;
        ra = parent;
      end
      OP_TGT:   ra = ONE_N;
      OP_DESC:  ra = next_leaf ? '0 : NODE_W'({next_node, 1'b1});
      default:  ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr_cnt <= clr_cnt + ONE_N;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_r  <= in_mode;
        leaf_r  <= in_leaf;
        delta_r <= in_delta;
        frac_r  <= frac_wide[FRACTION_BITS-1:0];
        cur     <= in_ok ? leaf_node : '0;
        clip    <= 1'b0;
        empty   <= 1'b0;
      end
      OP_UP: begin
        cur  <= parent;
        clip <= clip | clamp_hit;
        if (cur == '0) total <= clamped;
      end
      OP_MUL: begin
        total <= rd;
        empty <= (rd == '0);
        p_hi  <= frac_r * rd[WEIGHT_BITS-1:LO_W];
        p_lo  <= frac_r * rd[LO_W-1:0];
      end
      OP_TOTAL: total <= rd;
      OP_TGT: begin
        target <= prod[PROD_W-1:FRACTION_BITS];
        cur    <= '0;
        cumul  <= '0;
      end
      OP_DESC: begin
        cur <= next_node;
        if (!go_left) cumul <= left_sum;
      end
      default: ;
    endcase
    if (cmd.emit) begin
      if (!mode_r) out_leaf <= leaf_r;
      else if (empty) out_leaf <= '0;
      else out_leaf <= LEAF_PORT_W'(cur - FIRST_LEAF_N);
      out_total <= TOTAL_PORT_W'(total);
      out_empty <= empty;
      out_clip  <= clip;
    end
  end

  assign m_tdata = M_TDATA_W'({out_total, out_leaf});
  assign m_tuser = {out_clip, out_empty};

  assign st.in_update_ok = in_ok;
  assign st.in_sample    = in_mode;
  assign st.at_root      = (cur == '0);
  assign st.rd_zero      = (rd == '0);
  assign st.next_leaf    = next_leaf;
  assign st.clr_last     = (clr_cnt == LAST_NODE_N);

  `STW_ASSERT_NOW(a_desc_inner, cmd.op == OP_DESC, cur < FIRST_LEAF_N, "descent past leaf level")
  `STW_ASSERT_NOW(a_sample_leaf, cmd.emit && mode_r && !empty, cur >= FIRST_LEAF_N, "sample ended off a leaf")
  `STW_ASSERT_NOW(a_clear_range, cmd.op == OP_CLEAR, clr_cnt <= LAST_NODE_N, "clear beyond memory")

endmodule

// File: src/sum_tree_weighted_sampler_core.sv
`timescale 1ns / 1ps
// Sum tree weighted sampler, top level.
// Usage:
//   Input transfer: s_tuser = mode (0 update, 1 sample); s_tdata carries leaf,
//   signed delta and fraction. Output transfer: one result per input, m_tdata
//   carries the picked leaf and total_weight, m_tuser the empty and clipped flags.
//   Update: leaf node and each ancestor take the delta, each clamped to
//   0 .. 2^WEIGHT_BITS-1.
//   Sample: total times fraction sets a target, then one tree level per cycle
//   on the node memory read port; when the total is zero, the descent is
//   skipped. Leaves sit LEVELS = log2(LEAVES) levels below the root, 10 by default.
//   Out-of-range updates change nothing and still return a result.
//   One item is in work at a time; the next is taken once the current result
//   sits in the output register.
//   Reset: a clearing pass writes zero to all 2*LEAVES-1 nodes, one per cycle,
//   with s_tready low until it ends.
//   A stalled receiver holds the result; the block finishes its next item and
//   waits for the output register to free up.
module sum_tree_weighted_sampler_core import stw_pkg::*; #(
  parameter int LEAVES        = LEAVES_DEF,
  parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // leaf[9:0], delta[41:10], fraction[65:42], zero pad
  input  logic [S_TUSER_W-1:0] s_tuser,   // mode[0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // picked leaf[9:0], total_weight[41:10], zero pad
  output logic [M_TUSER_W-1:0] m_tuser    // empty_flag[0], clipped[1]
);

  cmd_t  cmd;
  stat_t st;

  stw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  stw_dp #(
    .LEAVES        (LEAVES),
    .WEIGHT_BITS   (WEIGHT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .st      (st),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
